/* hw/rtl/joystick_event_coalescer_assert.svh */
// Assertion macros for the joystick event coalescer.
// Included by joystick_event_coalescer to check its own control logic; needs nothing else.
`ifndef JOYSTICK_EVENT_COALESCER_ASSERT_SVH
`define JOYSTICK_EVENT_COALESCER_ASSERT_SVH

`ifndef SYNTH
`define JEC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define JEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define JEC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define JEC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/jec_pkg.sv */
// Shared types and constants of the joystick event coalescer.
// Used by jec_axis_scale and joystick_event_coalescer; depends on nothing.
`timescale 1ns / 1ps

package jec_pkg;

   localparam int JEC_MAX_BUTTONS = 32;
   localparam int JEC_MAX_AXES    = 16;

   localparam int DZ_W    = 15;
   localparam int GAIN_W  = 16;
   localparam int TIMER_W = 16;
   localparam int VALUE_W = 16;
   localparam int CSR_W   = 16;

   localparam int FRAC_BITS  = 12;
   localparam int ROUND_HALF = 2048;
   localparam int SAT_MAX    = 32767;

   localparam logic ACTION_EVENT = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   localparam logic [1:0] EVENT_BUTTON = 2'd0;
   localparam logic [1:0] EVENT_AXIS   = 2'd1;
   localparam logic [1:0] EVENT_OTHER2 = 2'd2;
   localparam logic [1:0] EVENT_OTHER3 = 2'd3;

   localparam logic [1:0] ENTRY_BUTTON = 2'd0;
   localparam logic [1:0] ENTRY_AXIS   = 2'd1;
   localparam logic [1:0] ENTRY_MARKER = 2'd2;

   localparam logic [1:0] CSR_DEADZONE = 2'd0;
   localparam logic [1:0] CSR_GAIN     = 2'd1;
   localparam logic [1:0] CSR_COALESCE = 2'd2;
   localparam logic [1:0] CSR_REPEAT   = 2'd3;

   localparam logic [DZ_W-1:0]    DEADZONE_RESET = 15'd1638;
   localparam logic [GAIN_W-1:0]  GAIN_RESET     = 16'd4311;
   localparam logic [TIMER_W-1:0] COALESCE_RESET = 16'd1;
   localparam logic [TIMER_W-1:0] REPEAT_RESET   = 16'd0;

   typedef struct packed {
      logic              action;
      logic [1:0]        event_kind;
      logic              init_flag;
      logic [7:0]        control_number;
      logic signed [15:0] raw_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         entry_kind;
      logic [4:0]         entry_index;
      logic signed [15:0] entry_value;
      logic               last_entry;
   } rsp_type;

   typedef struct packed {
      logic                      done;
      logic signed [VALUE_W-1:0] value;
   } scl_status_type;

endpackage

/* hw/rtl/jec_axis_scale.sv */
// Axis scaling unit: deadzone, shift-add gain multiply, rounding and saturation.
// Depends on jec_pkg.
`timescale 1ns / 1ps

module jec_axis_scale import jec_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [VALUE_W-1:0] raw_value,
   input  logic [DZ_W-1:0]           threshold,
   input  logic [GAIN_W-1:0]         gain,
   output scl_status_type            status
);

   localparam int STEP_W = $clog2(GAIN_W);
   localparam int PROD_W = 2 * VALUE_W;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN} scl_state_type;

   scl_state_type             state_ff, state_in;
   logic [PROD_W-1:0]         mcand_ff, mcand_in;
   logic [GAIN_W-1:0]         mplier_ff, mplier_in;
   logic [PROD_W-1:0]         acc_ff, acc_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic                      done_ff, done_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   logic signed [VALUE_W:0]   v_ext;
   logic signed [VALUE_W:0]   d_ext;
   logic                      above;
   logic                      below;
   logic signed [VALUE_W:0]   diff;
   logic [VALUE_W-1:0]        mag;
   logic [PROD_W:0]           rounded;
   logic [PROD_W-FRAC_BITS:0] quot;
   logic [VALUE_W-1:0]        sat;

   assign v_ext = {raw_value[VALUE_W-1], raw_value};
   assign d_ext = signed'({2'b00, threshold});
   assign above = v_ext > d_ext;
   assign below = v_ext < -d_ext;
   assign diff  = above ? (v_ext - d_ext) : (below ? (-v_ext - d_ext) : '0);
   assign mag   = diff[VALUE_W-1:0];

   assign rounded = {1'b0, acc_ff} + (PROD_W + 1)'(ROUND_HALF);
   assign quot    = rounded[PROD_W:FRAC_BITS];
   assign sat     = (quot > (PROD_W - FRAC_BITS + 1)'(SAT_MAX)) ? VALUE_W'(SAT_MAX)
                                                             : quot[VALUE_W-1:0];

   always_comb begin
      state_in  = state_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      done_in   = 1'b0;
      value_in  = value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mcand_in  = {{(PROD_W - VALUE_W){1'b0}}, mag};
               mplier_in = gain;
               acc_in    = '0;
               step_in   = '0;
               neg_in    = above;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(GAIN_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            value_in = neg_ff ? -signed'(sat) : signed'(sat);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      value_ff  <= value_in;
   end

   assign status.done  = done_ff;
   assign status.value = value_ff;

endmodule

/* hw/rtl/joystick_event_coalescer.sv */
// Joystick event coalescer top level: stores, timer, publication sequencer. Uses jec_pkg.
// A tick, a button request or an axis request with init_flag set does not use the scaler; any
// other axis request holds the block until the 16-step shift-add multiplier in jec_axis_scale is done.
// A publication shows one entry per cycle unless the output stalls, one per stored button and axis,
// or one marker entry if none is stored; requests resume once the last entry is registered.
// Synchronous reset restores register defaults and clears both stores, counts and the timer.
`timescale 1ns / 1ps
`include "joystick_event_coalescer_assert.svh"

module joystick_event_coalescer import jec_pkg::*; #(
   parameter int MAX_BUTTONS = JEC_MAX_BUTTONS,
   parameter int MAX_AXES    = JEC_MAX_AXES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   localparam int BW  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
   localparam int AW  = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
   localparam int BCW = $clog2(MAX_BUTTONS + 1);
   localparam int ACW = $clog2(MAX_AXES + 1);
   localparam int IW  = (BW > AW) ? BW : AW;

   typedef enum logic [2:0] {ST_IDLE, ST_SCALE, ST_BTN, ST_AXIS, ST_MARK} state_type;

   state_type                 state_ff, state_in;
   logic [MAX_BUTTONS-1:0]    btn_ff, btn_in;
   logic signed [VALUE_W-1:0] axis_ff [MAX_AXES];
   logic signed [VALUE_W-1:0] axis_in [MAX_AXES];
   logic [BCW-1:0]            btn_cnt_ff, btn_cnt_in;
   logic [ACW-1:0]            axis_cnt_ff, axis_cnt_in;
   logic [TIMER_W-1:0]        timer_ff, timer_in;
   logic                      armed_ff, armed_in;
   logic                      pending_ff, pending_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             axis_sel_ff, axis_sel_in;
   logic [DZ_W-1:0]           dz_ff, dz_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic [TIMER_W-1:0]        coal_ff, coal_in;
   logic [TIMER_W-1:0]        rep_ff, rep_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           is_tick;
   logic           is_btn;
   logic           is_axis;
   logic           now;
   logic           soon;
   logic           out_free;
   logic           btn_end;
   logic           axis_end;
   logic           scl_start;
   scl_status_type scl_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign is_tick   = (req_data.action == ACTION_TICK);
   assign is_btn    = !is_tick && (req_data.event_kind == EVENT_BUTTON)
                      && ({1'b0, req_data.control_number} < 9'(MAX_BUTTONS));
   assign is_axis   = !is_tick && (req_data.event_kind == EVENT_AXIS)
                      && ({1'b0, req_data.control_number} < 9'(MAX_AXES));
   assign scl_start = accept && is_axis && !req_data.init_flag;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign btn_end   = ((IW + 1)'(idx_ff) + 1'b1) == (IW + 1)'(btn_cnt_ff);
   assign axis_end  = ((IW + 1)'(idx_ff) + 1'b1) == (IW + 1)'(axis_cnt_ff);

   jec_axis_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (scl_start),
      .raw_value (req_data.raw_value),
      .threshold (dz_ff),
      .gain      (gain_ff),
      .status    (scl_status)
   );

   always_comb begin
      state_in     = state_ff;
      btn_in       = btn_ff;
      axis_in      = axis_ff;
      btn_cnt_in   = btn_cnt_ff;
      axis_cnt_in  = axis_cnt_ff;
      timer_in     = timer_ff;
      armed_in     = armed_ff;
      pending_in   = pending_ff;
      idx_in       = idx_ff;
      axis_sel_in  = axis_sel_ff;
      dz_in        = dz_ff;
      gain_in      = gain_ff;
      coal_in      = coal_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      now          = 1'b0;
      soon         = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEADZONE: dz_in   = csr_data[DZ_W-1:0];
            CSR_GAIN:     gain_in = csr_data[GAIN_W-1:0];
            CSR_COALESCE: coal_in = csr_data[TIMER_W-1:0];
            CSR_REPEAT:   rep_in  = csr_data[TIMER_W-1:0];
            default:      dz_in   = dz_ff;
         endcase
      end

      if (accept) begin
         if (is_tick) begin
            if (armed_ff) begin
               if (timer_ff <= TIMER_W'(1)) begin
                  timer_in = '0;
                  now      = 1'b1;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
         end else if (is_btn) begin
            if ({1'b0, req_data.control_number} >= 9'(btn_cnt_ff)) begin
               btn_cnt_in = BCW'({1'b0, req_data.control_number} + 9'd1);
            end
            btn_in[req_data.control_number[BW-1:0]] = (req_data.raw_value != '0);
            if (req_data.init_flag) begin
               soon = 1'b1;
            end else begin
               now = 1'b1;
            end
         end else if (is_axis) begin
            if ({1'b0, req_data.control_number} >= 9'(axis_cnt_ff)) begin
               axis_cnt_in = ACW'({1'b0, req_data.control_number} + 9'd1);
            end
            if (!req_data.init_flag) begin
               axis_sel_in = req_data.control_number[AW-1:0];
               state_in    = ST_SCALE;
            end
            soon = 1'b1;
         end

         if (now) begin
            armed_in   = 1'b0;
            pending_in = 1'b0;
            soon       = 1'b0;
            idx_in     = '0;
            if (btn_cnt_in != '0) begin
               state_in = ST_BTN;
            end else if (axis_cnt_in != '0) begin
               state_in = ST_AXIS;
            end else begin
               state_in = ST_MARK;
            end
         end
         if (!pending_in && soon) begin
            timer_in   = coal_ff;
            pending_in = 1'b1;
            armed_in   = 1'b1;
         end
         if (!armed_in && (rep_ff != '0)) begin
            timer_in = rep_ff;
            armed_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SCALE: begin
            if (scl_status.done) begin
               axis_in[axis_sel_ff] = scl_status.value;
               state_in             = ST_IDLE;
            end
         end
         ST_BTN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.entry_kind  = ENTRY_BUTTON;
               rsp_data_in.entry_index = 5'(idx_ff);
               rsp_data_in.entry_value = {{(VALUE_W - 1){1'b0}}, btn_ff[idx_ff[BW-1:0]]};
               rsp_data_in.last_entry  = btn_end && (axis_cnt_ff == '0);
               if (btn_end) begin
                  idx_in   = '0;
                  state_in = (axis_cnt_ff == '0) ? ST_IDLE : ST_AXIS;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_AXIS: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.entry_kind  = ENTRY_AXIS;
               rsp_data_in.entry_index = 5'(idx_ff);
               rsp_data_in.entry_value = axis_ff[idx_ff[AW-1:0]];
               rsp_data_in.last_entry  = axis_end;
               if (axis_end) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_MARK: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.entry_kind  = ENTRY_MARKER;
               rsp_data_in.entry_index = '0;
               rsp_data_in.entry_value = '0;
               rsp_data_in.last_entry  = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         btn_ff       <= '0;
         axis_ff      <= '{default: '0};
         btn_cnt_ff   <= '0;
         axis_cnt_ff  <= '0;
         timer_ff     <= '0;
         armed_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         idx_ff       <= '0;
         dz_ff        <= DEADZONE_RESET;
         gain_ff      <= GAIN_RESET;
         coal_ff      <= COALESCE_RESET;
         rep_ff       <= REPEAT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         btn_ff       <= btn_in;
         axis_ff      <= axis_in;
         btn_cnt_ff   <= btn_cnt_in;
         axis_cnt_ff  <= axis_cnt_in;
         timer_ff     <= timer_in;
         armed_ff     <= armed_in;
         pending_ff   <= pending_in;
         idx_ff       <= idx_in;
         dz_ff        <= dz_in;
         gain_ff      <= gain_in;
         coal_ff      <= coal_in;
         rep_ff       <= rep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_sel_ff <= axis_sel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `JEC_ASSERT_IMPLIES(a_pending_armed, clock, reset, pending_ff, armed_ff)
   `JEC_ASSERT_IMPLIES(a_scale_done_owned, clock, reset, scl_status.done, state_ff == ST_SCALE)
   `JEC_ASSERT_IMPLIES(a_counts_bounded, clock, reset, 1'b1,
      (btn_cnt_ff <= BCW'(MAX_BUTTONS)) && (axis_cnt_ff <= ACW'(MAX_AXES)))
   `JEC_ASSERT_IMPLIES(a_marker_last, clock, reset,
      rsp_valid_ff && (rsp_data_ff.entry_kind == ENTRY_MARKER), rsp_data_ff.last_entry)
   `JEC_ASSERT_NEXT(a_scale_start_busy, clock, reset, scl_start, state_ff == ST_SCALE)

endmodule
